// ===== rtl/ptzf_pkg.sv =====
// shared constants and types for the per-tone zf/mmse equalizer
// no dependencies
package ptzf_pkg;

   localparam int NOISE_W = 31;

   typedef logic [1:0] status_type;
   localparam status_type ST_OK   = 2'd0;
   localparam status_type ST_ZERO = 2'd1;
   localparam status_type ST_SAT  = 2'd2;

   typedef logic csr_addr_type;
   localparam csr_addr_type CSR_MODE  = 1'b0;
   localparam csr_addr_type CSR_NOISE = 1'b1;

   localparam logic MODE_ZF   = 1'b0;
   localparam logic MODE_MMSE = 1'b1;

endpackage

// ===== rtl/ptzf_div_lane.sv =====
// pipelined restoring divider lane, one quotient bit per stage
// depends on ptzf_pkg; stage enables come from the top level
module ptzf_div_lane #(
   parameter int W  = 16,
   parameter int DW = 33
) (
   input  logic           clock,
   input  logic [W:0]     en,
   input  logic [2*W-1:0] mag,
   input  logic [DW-1:0]  den,
   input  logic           neg,
   output logic [W:0]     quo,
   output logic           ovf,
   output logic           neg_out
);
   import ptzf_pkg::*;

   localparam int RW = DW + W + 1;
   localparam int F  = W - 5;

   logic [RW-1:0] r_ff [0:W];
   logic [RW-1:0] r_in [0:W];
   logic [DW-1:0] d_ff [0:W];
   logic [W:0]    q_ff [0:W];
   logic [W:0]    q_in [0:W];
   logic          ovf_ff [0:W];
   logic          neg_ff [0:W];

   genvar k;
   generate
      for (k = 0; k <= W; k++) begin : g_stage
         logic [RW-1:0] r_prev;
         logic [DW-1:0] d_prev;
         logic [W:0]    q_prev;
         logic          ovf_prev;
         logic          neg_prev;
         logic [RW-1:0] trial;
         if (k == 0) begin : g_first
            assign r_prev   = RW'(mag) << (F + 1);
            assign d_prev   = den;
            assign q_prev   = '0;
            assign ovf_prev = (RW'(mag) >= (RW'(den) << 5));
            assign neg_prev = neg;
         end else begin : g_rest
            assign r_prev   = r_ff[k-1];
            assign d_prev   = d_ff[k-1];
            assign q_prev   = q_ff[k-1];
            assign ovf_prev = ovf_ff[k-1];
            assign neg_prev = neg_ff[k-1];
         end
         assign trial = RW'(d_prev) << (W - k);
         always_comb begin
            r_in[k] = r_prev;
            q_in[k] = q_prev;
            if (r_prev >= trial) begin
               r_in[k] = r_prev - trial;
               q_in[k][W-k] = 1'b1;
            end
         end
         always_ff @(posedge clock) begin
            if (en[k]) begin
               r_ff[k]   <= r_in[k];
               d_ff[k]   <= d_prev;
               q_ff[k]   <= q_in[k];
               ovf_ff[k] <= ovf_prev;
               neg_ff[k] <= neg_prev;
            end
         end
      end
   endgenerate

   assign quo     = q_ff[W];
   assign ovf     = ovf_ff[W];
   assign neg_out = neg_ff[W];
endmodule

// ===== rtl/per_tone_zf_mmse_equalizer.sv =====
// top level of the per-tone zf/mmse equalizer: multiply, sum, divide, round
// depends on ptzf_pkg and ptzf_div_lane
//
// Usage: one received tone and its channel estimate enter as a word on the
// req_ stream; one equalized symbol leaves on the rsp_ stream for each word.
// csr_wen writes equalizer_mode (index 0) or noise_variance (index 1) on the
// rising edge; write only while the pipeline is empty.
// The pipeline has one multiply stage, one add stage, one magnitude stage,
// SAMPLE_WIDTH+1 divider stages that each settle one quotient bit, and one
// rounding and saturation stage. Throughput is one word per cycle while
// rsp_tready is high; the divider stages are fully pipelined.
// Each stage carries a valid bit and holds while the next one is full and
// stalled, so empty stages fill up while rsp_tready is low and nothing is
// lost or repeated. req_tready is low only when every stage is full.
// Synchronous reset empties the pipeline and sets MMSE mode, zero noise.
// rsp_tuser carries status: ok, zero denominator (output zero) or saturated.
module per_tone_zf_mmse_equalizer #(
   parameter int SAMPLE_WIDTH = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   // rx_re, rx_im, chan_re, chan_im, zero pad
   input  logic [((4*SAMPLE_WIDTH+7)/8)*8-1:0] req_tdata,
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   // eq_re, eq_im, zero pad
   output logic [((2*SAMPLE_WIDTH+7)/8)*8-1:0] rsp_tdata,
   // status
   output ptzf_pkg::status_type     rsp_tuser,
   input  logic                     csr_wen,
   input  ptzf_pkg::csr_addr_type   csr_addr,
   input  logic [ptzf_pkg::NOISE_W-1:0] csr_wdata
);
   import ptzf_pkg::*;

   localparam int W  = SAMPLE_WIDTH;
   localparam int DW = ((2 * W > NOISE_W) ? 2 * W : NOISE_W) + 1;
   localparam int N  = W + 5;
   localparam int LS = 3;

   logic               mode_ff;
   logic [NOISE_W-1:0] noise_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_MMSE;
         noise_ff <= '0;
      end else if (csr_wen) begin
         case (csr_addr)
            CSR_MODE:  mode_ff  <= csr_wdata[0];
            CSR_NOISE: noise_ff <= csr_wdata;
            default:   ;
         endcase
      end
   end

   logic       vld_ff [0:N-1];
   logic [N:0] en;

   always_comb begin
      en[N] = rsp_tready;
      for (int i = N - 1; i >= 0; i--) begin
         en[i] = !vld_ff[i] || en[i+1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < N; i++) begin
            vld_ff[i] <= 1'b0;
         end
      end else begin
         for (int i = 0; i < N; i++) begin
            if (en[i]) begin
               vld_ff[i] <= (i == 0) ? req_tvalid : vld_ff[(i == 0) ? 0 : i - 1];
            end
         end
      end
   end

   assign req_tready = en[0];

   // stage 0: products
   logic signed [W-1:0] yr, yi, hr, hi;
   assign yr = req_tdata[W-1:0];
   assign yi = req_tdata[2*W-1:W];
   assign hr = req_tdata[3*W-1:2*W];
   assign hi = req_tdata[4*W-1:3*W];

   logic signed [2*W-1:0] p_rr_ff, p_ii_ff, p_ir_ff, p_ri_ff, p_hr_ff, p_hi_ff;

   always_ff @(posedge clock) begin
      if (en[0]) begin
         p_rr_ff <= yr * hr;
         p_ii_ff <= yi * hi;
         p_ir_ff <= yi * hr;
         p_ri_ff <= yr * hi;
         p_hr_ff <= hr * hr;
         p_hi_ff <= hi * hi;
      end
   end

   // stage 1: sums and denominator
   logic signed [2*W:0] nre_ff, nim_ff;
   logic [DW-1:0]       den1_ff;
   logic [DW-1:0]       pw;

   assign pw = DW'(unsigned'(p_hr_ff)) + DW'(unsigned'(p_hi_ff));

   always_ff @(posedge clock) begin
      if (en[1]) begin
         nre_ff  <= (2*W+1)'(p_rr_ff) + (2*W+1)'(p_ii_ff);
         nim_ff  <= (2*W+1)'(p_ir_ff) - (2*W+1)'(p_ri_ff);
         den1_ff <= pw + ((mode_ff == MODE_MMSE) ? DW'(noise_ff) : DW'(0));
      end
   end

   // stage 2: sign and magnitude
   logic [2*W-1:0] mag_re_ff, mag_im_ff;
   logic           neg_re_ff, neg_im_ff, zero2_ff;
   logic [DW-1:0]  den2_ff;
   logic [2*W:0]   abs_re, abs_im;

   assign abs_re = nre_ff[2*W] ? (2*W+1)'(-nre_ff) : nre_ff;
   assign abs_im = nim_ff[2*W] ? (2*W+1)'(-nim_ff) : nim_ff;

   always_ff @(posedge clock) begin
      if (en[2]) begin
         mag_re_ff <= abs_re[2*W-1:0];
         mag_im_ff <= abs_im[2*W-1:0];
         neg_re_ff <= nre_ff[2*W];
         neg_im_ff <= nim_ff[2*W];
         den2_ff   <= den1_ff;
         zero2_ff  <= (den1_ff == '0);
      end
   end

   // divider stages
   logic [W:0] quo_re, quo_im;
   logic       ovf_re, ovf_im, nro, nio;
   logic       zero_ff [0:W];

   ptzf_div_lane #(.W(W), .DW(DW)) u_lane_re (
      .clock   (clock),
      .en      (en[LS+W:LS]),
      .mag     (mag_re_ff),
      .den     (den2_ff),
      .neg     (neg_re_ff),
      .quo     (quo_re),
      .ovf     (ovf_re),
      .neg_out (nro)
   );

   ptzf_div_lane #(.W(W), .DW(DW)) u_lane_im (
      .clock   (clock),
      .en      (en[LS+W:LS]),
      .mag     (mag_im_ff),
      .den     (den2_ff),
      .neg     (neg_im_ff),
      .quo     (quo_im),
      .ovf     (ovf_im),
      .neg_out (nio)
   );

   always_ff @(posedge clock) begin
      for (int k = 0; k <= W; k++) begin
         if (en[LS+k]) begin
            zero_ff[k] <= (k == 0) ? zero2_ff : zero_ff[(k == 0) ? 0 : k - 1];
         end
      end
   end

   // final stage: round, saturate, sign
   logic [W-1:0] res_re, res_im;
   logic         sat_re, sat_im;

   function automatic logic [W:0] round_sat(input logic [W:0] q, input logic neg,
                                            input logic ovf, output logic sat);
      logic [W+1:0] sum;
      logic [W:0]   rnd, lim, val;
      sum = {1'b0, q} + (W+2)'(1);
      rnd = sum[W+1:1];
      lim = neg ? ((W+1)'(1) << (W - 1)) : (((W+1)'(1) << (W - 1)) - (W+1)'(1));
      sat = ovf || (rnd > lim);
      val = sat ? lim : rnd;
      return neg ? (W+1)'(-val) : val;
   endfunction

   logic [W:0] rr, ri;
   always_comb begin
      rr = round_sat(quo_re, nro, ovf_re, sat_re);
      ri = round_sat(quo_im, nio, ovf_im, sat_im);
      res_re = rr[W-1:0];
      res_im = ri[W-1:0];
   end

   logic [W-1:0] eq_re_ff, eq_im_ff;
   status_type   status_ff;

   always_ff @(posedge clock) begin
      if (en[N-1]) begin
         if (zero_ff[W]) begin
            eq_re_ff  <= '0;
            eq_im_ff  <= '0;
            status_ff <= ST_ZERO;
         end else begin
            eq_re_ff  <= res_re;
            eq_im_ff  <= res_im;
            status_ff <= (sat_re || sat_im) ? ST_SAT : ST_OK;
         end
      end
   end

   assign rsp_tvalid = vld_ff[N-1];
   assign rsp_tdata  = ($bits(rsp_tdata))'({eq_im_ff, eq_re_ff});
   assign rsp_tuser  = status_ff;
endmodule
